@@ rtl/core/kwsc_pkg.sv @@
// Shared constants and types for the keyword substitution cipher.
package kwsc_pkg;

   localparam int KeyLen   = 5;
   localparam int AlphaLen = 26;

   localparam int LetterW = 5;
   localparam int CharW   = 8;
   localparam int CsrIdxW = 3;

   localparam logic [CharW-1:0] CharLowerA = 8'h61;
   localparam logic [CharW-1:0] CharLowerZ = 8'h7A;
   localparam logic [CharW-1:0] CharUpperA = 8'h41;
   localparam logic [CharW-1:0] CharUpperZ = 8'h5A;

   localparam logic [LetterW-1:0] LastLetter = LetterW'(AlphaLen - 1);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KEY0      = 3'd0,
      CSR_KEY1      = 3'd1,
      CSR_KEY2      = 3'd2,
      CSR_KEY3      = 3'd3,
      CSR_KEY4      = 3'd4,
      CSR_DIRECTION = 3'd5
   } csr_index_type;

   typedef logic [LetterW-1:0] letter_type;

endpackage

@@ rtl/core/keyword_substitution_cipher_top.sv @@
// Keyword substitution cipher: lookup tables, rebuild sweep and two-stage datapath.

// Takes one byte per cycle on the req_ channel and returns one byte per cycle on the
// rsp_ channel unless stalled, with an output register that lets a new byte enter while
// a result still waits. The cipher alphabet lives in two 26-entry memories (forward and
// inverse), each with a registered read; a letter is looked up at its alphabet position
// and rebased to its original case, anything else passes through. The tables are
// rebuilt by a sweep, one letter per cycle unless a CSR write holds it, after reset and
// after every key letter write; req_ready is low during the sweep. A repeated key
// letter or one above z sets rsp_key_error and passes every byte through.
module keyword_substitution_cipher_top
   import kwsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CharW-1:0]   req_char_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CharW-1:0]   rsp_char_out,
   output logic               rsp_key_error,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [LetterW-1:0] csr_wdata
);

   // configuration
   letter_type key_ff [KeyLen];
   logic       dir_ff;

   // rebuild sweep
   logic       sweep_ff, sweep_in;
   letter_type cnt_ff, cnt_in;
   letter_type free_ff, free_in;

   // tables
   letter_type enc_mem [AlphaLen];
   letter_type dec_mem [AlphaLen];
   letter_type enc_rd_ff, dec_rd_ff;

   // datapath
   logic             s1_valid_ff, s1_valid_in;
   logic [CharW-1:0] s1_char_ff;
   logic             s1_lower_ff, s1_upper_ff, s1_err_ff, s1_dir_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CharW-1:0] rsp_char_ff, rsp_char_in;
   logic             rsp_err_ff;

   logic       key_err;
   logic       key_hit;
   letter_type sweep_pos;
   logic       sweep_wr;
   logic       in_lower, in_upper;
   letter_type rd_idx;
   logic       req_xfer, s1_adv;
   letter_type mapped;
   logic [CharW-1:0] base;

   // key validity: every letter in range and all distinct
   always_comb begin
      key_err = 1'b0;
      for (int i = 0; i < KeyLen; i++) begin
         if (key_ff[i] > LastLetter) key_err = 1'b1;
         for (int j = i + 1; j < KeyLen; j++) begin
            if (key_ff[i] == key_ff[j]) key_err = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KeyLen; i++) key_ff[i] <= LetterW'(i);
         dir_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index < CsrIdxW'(KeyLen)) key_ff[csr_index] <= csr_wdata;
         else if (csr_index == CSR_DIRECTION) dir_ff <= csr_wdata[0];
      end
   end

   // sweep: letter cnt_ff goes to its key slot, or to the next free slot after the key
   always_comb begin
      key_hit   = 1'b0;
      sweep_pos = LetterW'(KeyLen) + free_ff;
      for (int j = KeyLen - 1; j >= 0; j--) begin
         if (key_ff[j] == cnt_ff) begin
            key_hit   = 1'b1;
            sweep_pos = LetterW'(j);
         end
      end
   end

   assign sweep_wr = sweep_ff && !csr_we;

   always_comb begin
      sweep_in = sweep_ff;
      cnt_in   = cnt_ff;
      free_in  = free_ff;
      if (csr_we && csr_index < CsrIdxW'(KeyLen)) begin
         // restart with the new key
         sweep_in = 1'b1;
         cnt_in   = '0;
         free_in  = '0;
      end else if (sweep_wr) begin
         cnt_in  = cnt_ff + 1'b1;
         free_in = key_hit ? free_ff : free_ff + 1'b1;
         if (cnt_ff == LastLetter) sweep_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= 1'b1;
         cnt_ff   <= '0;
         free_ff  <= '0;
      end else begin
         sweep_ff <= sweep_in;
         cnt_ff   <= cnt_in;
         free_ff  <= free_in;
      end
   end

   // input side
   assign in_lower = (req_char_in >= CharLowerA) && (req_char_in <= CharLowerZ);
   assign in_upper = (req_char_in >= CharUpperA) && (req_char_in <= CharUpperZ);

   always_comb begin
      rd_idx = '0;
      if (in_lower)      rd_idx = LetterW'(req_char_in - CharLowerA);
      else if (in_upper) rd_idx = LetterW'(req_char_in - CharUpperA);
   end

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !sweep_ff && (!s1_valid_ff || s1_adv);
   assign req_xfer  = req_valid && req_ready;

   // table memories; read only on a transfer so the data holds while stage 1 stalls
   always_ff @(posedge clock) begin
      if (sweep_wr) begin
         enc_mem[sweep_pos] <= cnt_ff;
         dec_mem[cnt_ff]    <= sweep_pos;
      end
      if (req_xfer) begin
         enc_rd_ff <= enc_mem[rd_idx];
         dec_rd_ff <= dec_mem[rd_idx];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer)    s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_char_ff  <= req_char_in;
         s1_lower_ff <= in_lower;
         s1_upper_ff <= in_upper;
         s1_err_ff   <= key_err;
         s1_dir_ff   <= dir_ff;
      end
   end

   // output stage
   assign mapped = s1_dir_ff ? dec_rd_ff : enc_rd_ff;
   assign base   = s1_lower_ff ? CharLowerA : CharUpperA;

   always_comb begin
      rsp_char_in = s1_char_ff;
      if (!s1_err_ff && (s1_lower_ff || s1_upper_ff)) rsp_char_in = base + CharW'(mapped);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv)         rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_char_ff <= rsp_char_in;
         rsp_err_ff  <= s1_err_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_out  = rsp_char_ff;
   assign rsp_key_error = rsp_err_ff;

endmodule
